// ----- design/bitmap_font_text_renderer_top_defines.svh -----
// assertion macros for the bitmap font text renderer
`ifndef BITMAP_FONT_TEXT_RENDERER_TOP_DEFINES_SVH
`define BITMAP_FONT_TEXT_RENDERER_TOP_DEFINES_SVH

// same-cycle implication
`define BFR_ASSERT_IMPL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define BFR_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ----- design/bfr_pkg.sv -----
// shared types and constants for the bitmap font text renderer
`timescale 1ns / 1ps
package bfr_pkg;

  localparam int DEF_GLYPH_SLOTS = 256;
  localparam int DEF_MAX_HEIGHT  = 32;
  localparam int DEF_MAX_WIDTH   = 32;
  localparam int ROW_LIMIT       = 32;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SEARCH_SLOTS = 2'd2;

  localparam logic [5:0] RST_GLYPH_WIDTH  = 6'd8;
  localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [8:0] RST_SEARCH_SLOTS = 9'd0;

  typedef enum logic [1:0] {
    CMD_LOAD_CODE = 2'd0,
    CMD_LOAD_ROW  = 2'd1,
    CMD_PRINT     = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         slot;
    logic [4:0]         row_index;
    logic [31:0]        row_pattern;
    logic [31:0]        glyph_code;
    logic [7:0]         char_code;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [31:0]        color;
    logic               first;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [31:0]        row_mask;
    logic [31:0]        color_out;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic [31:0] code;
  } code_wr_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  row_index;
    logic [31:0] bits;
  } row_wr_t;

  typedef struct packed {
    logic done;
    logic found;
  } srch_res_t;

  typedef struct packed {
    logic        start;
    logic [5:0]  height;
    logic [31:0] mask;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] color;
  } rast_req_t;

endpackage

// ----- design/bfr_search.sv -----
// glyph code memory and sequential code search
`timescale 1ns / 1ps
module bfr_search
  import bfr_pkg::*;
#(
  parameter  int GLYPH_SLOTS = DEF_GLYPH_SLOTS,
  localparam int SLOT_W      = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  code_wr_t               wr,
  input  logic [SLOT_W-1:0]      wr_slot,
  input  logic [8:0]             search_slots,
  input  logic                   start,
  input  logic [7:0]             char_code,
  output srch_res_t              res,
  output logic [SLOT_W-1:0]      res_slot
);

  localparam int CNT_W  = $clog2(GLYPH_SLOTS + 1);
  localparam int CW     = (CNT_W > 9) ? CNT_W : 9;

  typedef enum logic [0:0] {S_IDLE, S_SCAN} state_t;

  state_t          state;
  logic [31:0]     codes [GLYPH_SLOTS];
  logic [31:0]     rd_data;
  logic [7:0]      code_r;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   lim_next;
  logic [CW-1:0]   iss;
  logic [CW-1:0]   chk_idx;
  logic            chk_v;
  logic            rd_en;
  logic            done_r;
  logic            found_r;
  logic [SLOT_W-1:0] slot_r;

  always_comb begin
    lim_next = CW'(search_slots);
    if (lim_next > CW'(GLYPH_SLOTS)) begin
      lim_next = CW'(GLYPH_SLOTS);
    end
  end

  assign rd_en = (state == S_SCAN) && (iss < lim);

  always_ff @(posedge clk) begin
    if (wr.we) begin
      codes[wr_slot] <= wr.code;
    end
    if (rd_en) begin
      rd_data <= codes[iss[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      chk_v   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done_r <= 1'b0;
          if (start) begin
            code_r <= char_code;
            lim    <= lim_next;
            iss    <= '0;
            chk_v  <= 1'b0;
            if (lim_next == '0) begin
              done_r  <= 1'b1;
              found_r <= 1'b0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_v   <= rd_en;
          chk_idx <= iss;
          if (rd_en) begin
            iss <= iss + CW'(1);
          end
          if (chk_v && (rd_data == {24'd0, code_r})) begin
            done_r  <= 1'b1;
            found_r <= 1'b1;
            slot_r  <= chk_idx[SLOT_W-1:0];
            state   <= S_IDLE;
          end else if (chk_v && (chk_idx == lim - CW'(1))) begin
            done_r  <= 1'b1;
            found_r <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.found = found_r;
  assign res_slot  = slot_r;

endmodule

// ----- design/bfr_raster.sv -----
// glyph row memory and row emitter with output register
`timescale 1ns / 1ps
module bfr_raster
  import bfr_pkg::*;
#(
  parameter  int GLYPH_SLOTS = DEF_GLYPH_SLOTS,
  parameter  int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  localparam int SLOT_W      = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  row_wr_t           ld,
  input  logic [SLOT_W-1:0] ld_slot,
  input  rast_req_t         req,
  input  logic [SLOT_W-1:0] req_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  output logic              done
);

  localparam int DEPTH  = GLYPH_SLOTS * MAX_HEIGHT;
  localparam int RA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]     rows [DEPTH];
  logic [31:0]     rd_data;
  logic [RA_W-1:0] base_r;
  logic [RA_W-1:0] base_calc;
  logic [RA_W-1:0] base_sel;
  logic [RA_W-1:0] rd_addr;
  logic [RA_W-1:0] wr_addr;
  logic [5:0]      r;
  logic [5:0]      r_next;
  logic [5:0]      h_r;
  logic [5:0]      h_sel;
  logic [31:0]     mask_r;
  logic [15:0]     x_r;
  logic [15:0]     y_r;
  logic [31:0]     color_r;
  logic            last_r;
  logic            adv;
  logic            rd_en;

  assign adv       = out_valid && out_ready && !last_r;
  assign done      = out_valid && out_ready && last_r;
  assign rd_en     = req.start || adv;
  assign r_next    = req.start ? 6'd0 : r + 6'd1;
  assign h_sel     = req.start ? req.height : h_r;
  assign base_calc = RA_W'(req_slot) * RA_W'(MAX_HEIGHT);
  assign base_sel  = req.start ? base_calc : base_r;
  assign rd_addr   = base_sel + RA_W'(r_next);
  assign wr_addr   = RA_W'(ld_slot) * RA_W'(MAX_HEIGHT) + RA_W'(ld.row_index);

  always_ff @(posedge clk) begin
    if (ld.we) begin
      rows[wr_addr] <= ld.bits;
    end
    if (rd_en) begin
      rd_data <= rows[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_en) begin
      out_valid <= 1'b1;
    end else if (done) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      base_r  <= base_calc;
      h_r     <= req.height;
      mask_r  <= req.mask;
      x_r     <= req.x;
      y_r     <= req.y;
      color_r <= req.color;
    end else if (adv) begin
      y_r <= y_r + 16'd1;
    end
    if (rd_en) begin
      r      <= r_next;
      last_r <= (r_next == h_sel - 6'd1);
    end
  end

  assign out_data.pixel_x   = x_r;
  assign out_data.pixel_y   = y_r;
  assign out_data.row_mask  = rd_data & mask_r;
  assign out_data.color_out = color_r;
  assign out_data.last      = last_r;

endmodule

// ----- design/bitmap_font_text_renderer_top.sv -----
// top level of the bitmap font text renderer: pen state, config and sequencing
// load items and newlines are taken without leaving idle; a print item scans the code
// memory at one slot per cycle up to search_slots (capped at GLYPH_SLOTS), stopping at
// the first match, then emits one row per cycle while out_ready is high
// rst is synchronous: pen, config and control return to reset values
// the glyph code and row memories are not cleared and hold nothing valid until written
`timescale 1ns / 1ps
`include "bitmap_font_text_renderer_top_defines.svh"
module bitmap_font_text_renderer_top
  import bfr_pkg::*;
#(
  parameter int GLYPH_SLOTS = DEF_GLYPH_SLOTS,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int SLOT_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int CNT_W  = $clog2(GLYPH_SLOTS + 1);
  localparam int CW     = (CNT_W > 9) ? CNT_W : 9;
  localparam int HLIM   = (MAX_HEIGHT < ROW_LIMIT) ? MAX_HEIGHT : ROW_LIMIT;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_RASTER} state_t;

  state_t      state;
  logic [5:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [8:0]  search_slots;
  logic [15:0] pen_col;
  logic [15:0] pen_row;
  logic [15:0] line_start_col;
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [31:0] cur_color;
  logic [5:0]  cur_h;
  logic [31:0] cur_mask;

  logic [5:0]  w_eff;
  logic [5:0]  h_eff;
  logic [31:0] mask_calc;
  logic [15:0] col_base;
  logic [15:0] row_base;
  logic [15:0] lsc_base;
  logic        in_acc;
  logic        is_print;
  logic        is_nl;
  logic [CW-1:0]     slot_ext;
  logic [SLOT_W-1:0] wr_slot;
  logic              slot_ok;
  logic              row_ok;

  code_wr_t          code_wr;
  row_wr_t           row_wr;
  srch_res_t         srch_res;
  logic [SLOT_W-1:0] srch_slot;
  logic              srch_start;
  rast_req_t         rast_req;
  logic              rast_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= RST_GLYPH_WIDTH;
      glyph_height <= RST_GLYPH_HEIGHT;
      search_slots <= RST_SEARCH_SLOTS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[5:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data[5:0];
        REG_SEARCH_SLOTS: search_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (glyph_width == 6'd0) begin
      w_eff = 6'd1;
    end else if (glyph_width > 6'(MAX_WIDTH)) begin
      w_eff = 6'(MAX_WIDTH);
    end else begin
      w_eff = glyph_width;
    end
    if (glyph_height == 6'd0) begin
      h_eff = 6'd1;
    end else if (glyph_height > 6'(HLIM)) begin
      h_eff = 6'(HLIM);
    end else begin
      h_eff = glyph_height;
    end
  end

  assign mask_calc = 32'hFFFF_FFFF >> (6'd32 - w_eff);

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_print = (in_data.cmd == CMD_PRINT);
  assign is_nl    = (in_data.char_code == NEWLINE_CODE);

  assign col_base = in_data.first ? $unsigned(in_data.start_x) : pen_col;
  assign row_base = in_data.first ? $unsigned(in_data.start_y) : pen_row;
  assign lsc_base = in_data.first ? $unsigned(in_data.start_x) : line_start_col;

  assign slot_ext = CW'(in_data.slot);
  assign wr_slot  = slot_ext[SLOT_W-1:0];
  assign slot_ok  = slot_ext < CW'(GLYPH_SLOTS);
  assign row_ok   = {2'b00, in_data.row_index} < 7'(MAX_HEIGHT);

  assign code_wr.we   = in_acc && (in_data.cmd == CMD_LOAD_CODE) && slot_ok;
  assign code_wr.code = in_data.glyph_code;

  assign row_wr.we        = in_acc && (in_data.cmd == CMD_LOAD_ROW) && slot_ok && row_ok;
  assign row_wr.row_index = in_data.row_index;
  assign row_wr.bits      = in_data.row_pattern;

  assign srch_start = in_acc && is_print && !is_nl;

  assign rast_req.start  = (state == S_SEARCH) && srch_res.done && srch_res.found;
  assign rast_req.height = cur_h;
  assign rast_req.mask   = cur_mask;
  assign rast_req.x      = cur_x;
  assign rast_req.y      = cur_y;
  assign rast_req.color  = cur_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pen_col        <= '0;
      pen_row        <= '0;
      line_start_col <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && is_print) begin
            line_start_col <= lsc_base;
            if (is_nl) begin
              pen_col <= lsc_base;
              pen_row <= row_base + 16'(h_eff) + 16'd1;
            end else begin
              pen_col   <= col_base + 16'(w_eff) + 16'd1;
              pen_row   <= row_base;
              cur_x     <= col_base;
              cur_y     <= row_base;
              cur_color <= in_data.color;
              cur_h     <= h_eff;
              cur_mask  <= mask_calc;
              state     <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (srch_res.done) begin
            state <= srch_res.found ? S_RASTER : S_IDLE;
          end
        end
        S_RASTER: begin
          if (rast_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bfr_search #(
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .wr           (code_wr),
    .wr_slot      (wr_slot),
    .search_slots (search_slots),
    .start        (srch_start),
    .char_code    (in_data.char_code),
    .res          (srch_res),
    .res_slot     (srch_slot)
  );

  bfr_raster #(
    .GLYPH_SLOTS (GLYPH_SLOTS),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_raster (
    .clk       (clk),
    .rst       (rst),
    .ld        (row_wr),
    .ld_slot   (wr_slot),
    .req       (rast_req),
    .req_slot  (srch_slot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .done      (rast_done)
  );

  `BFR_ASSERT_IMPL(a_out_only_raster, clk, rst, out_valid, state == S_RASTER, "result outside raster")
  `BFR_ASSERT_NEXT(a_print_searches, clk, rst, srch_start, state == S_SEARCH, "print did not search")
  `BFR_ASSERT_NEXT(a_hit_rasters, clk, rst, rast_req.start, out_valid && state == S_RASTER, "hit did not raster")

endmodule
